FILE: src/ypd_pkg.sv
`default_nettype none

package ypd_pkg;

    // Quotient bits produced by the shared serial divider.
    localparam int QB = 27;

    // Fraction bits of the normalised difference.
    localparam int NORM_FRAC = 16;

    localparam logic [17:0] SR_RESET   = 18'd48000;
    localparam logic [9:0]  LMIN_RESET = 10'd24;
    localparam logic [9:0]  LMAX_RESET = 10'd1023;
    localparam logic [15:0] THR_RESET  = 16'd9830;

    localparam logic [16:0] NORM_ONE       = 17'd65536;
    localparam logic [15:0] FALLBACK_LIMIT = 16'd32768;
    localparam logic [17:0] PERIOD_MAX     = 18'h3FFFF;
    localparam logic [21:0] FREQ_MAX       = 22'h3FFFFF;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_SHORT = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_LAG_MIN     = 2'd1,
        REG_LAG_MAX     = 2'd2,
        REG_THRESHOLD   = 2'd3
    } cfg_reg_t;

    // What one cell hands to its neighbour each cycle.
    typedef struct packed {
        logic signed [15:0] a;
        logic               vld;
        logic signed [15:0] b;
    } link_t;

endpackage

`default_nettype wire

FILE: src/yin_pitch_detector_unit.sv
`default_nettype none

// Samples are taken one per cycle while loading.
// The run time is set by the cell chain sweeping the sample store and the serial divider.
// Throughput: one window at a time; a new window loads as soon as the result is registered.
// Reset (aresetn low, synchronous) restores register defaults and empties the sample count.
module yin_pitch_detector_unit #(
    parameter int WINDOW = 2048,
    parameter int LANES  = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tlast,   // last_sample
    // Result stream.
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [63:0] m_tdata    // [1:0] status, [23:2] frequency,
                                        // [41:24] period, [58:42] confidence
);

    // Sizes that follow from the window length.
    localparam int SA_W  = $clog2(WINDOW);
    localparam int HALF  = WINDOW / 2;
    localparam int LA_W  = $clog2(HALF);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LW    = (CNT_W > 11) ? CNT_W : 11;
    localparam int D_W   = 32 + LA_W;
    localparam int RS_W  = D_W + LA_W;
    localparam int DIV_W = RS_W + 1;
    localparam int NV_W  = LA_W + 18;
    localparam int LN_W  = $clog2(LANES);
    localparam int FC_W  = $clog2(HALF + 2 * LANES + 8);
    localparam int AX_W  = ((FC_W > LW) ? FC_W : LW) + 1;
    localparam int XW    = NV_W + 11;
    localparam int KX_W  = NV_W + 13;
    localparam int QB    = ypd_pkg::QB;

    // One-hot sequencer: load, cell sweeps, normalisation, search,
    // interpolation, frequency, hand-over of the result.
    typedef enum logic [21:0] {
        S_LOAD   = 22'h000001,
        S_CLR    = 22'h000002,
        S_FEED   = 22'h000004,
        S_WOUT   = 22'h000008,
        S_N_RD   = 22'h000010,
        S_N_MUL  = 22'h000020,
        S_N_DIV0 = 22'h000040,
        S_N_DIV  = 22'h000080,
        S_BOUNDS = 22'h000100,
        S_F_RD   = 22'h000200,
        S_F_CHK  = 22'h000400,
        S_D_RD   = 22'h000800,
        S_D_CHK  = 22'h001000,
        S_I_RD0  = 22'h002000,
        S_I_RD2  = 22'h004000,
        S_I_CALC = 22'h008000,
        S_I_PREP = 22'h010000,
        S_I_CHK  = 22'h020000,
        S_I_DIV  = 22'h040000,
        S_PER    = 22'h080000,
        S_Q_DIV  = 22'h100000,
        S_DONE   = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [17:0] sr_reg, sr_next;
    logic [9:0]  lmin_reg, lmin_next, lmax_reg, lmax_next;
    logic [15:0] thr_reg, thr_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [LW-1:0]    half_reg, half_next;
    logic [AX_W-1:0]  n_reg, n_next;
    logic [LW-1:0]    t0_reg, t0_next;
    logic [LN_W-1:0]  k_reg, k_next;
    logic [LW-1:0]    t_reg, t_next;
    logic [RS_W-1:0]  rs_reg, rs_next, prod_reg, prod_next;
    logic [LW-1:0]    hi_reg, hi_next, best_reg, best_next;
    logic [LW-1:0]    tau_reg, tau_next;
    logic [NV_W-1:0]  min_reg, min_next, val_reg, val_next, s0_reg, s0_next;
    logic signed [NV_W+9:0] num_reg, num_next;
    logic signed [NV_W+3:0] den_reg, den_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [NV_W+3:0]  y_reg, y_next;
    logic             neg_reg, neg_next;
    logic signed [9:0] off_reg, off_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [21:0]      res_freq_reg, res_freq_next;
    logic [17:0]      res_period_reg, res_period_next;
    logic [16:0]      res_conf_reg, res_conf_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg, m_tdata_next;

    // Sample store: written while loading, read at two addresses by the sweep.
    logic [15:0]     smem [WINDOW];
    logic            smem_we;
    logic [SA_W-1:0] sa_addr, sb_addr;
    logic [15:0]     ra_data_reg, rb_data_reg;
    logic            feed_vld, rd_vld_reg;

    // Difference store: raw sums from the cells, then normalised values.
    logic [D_W-1:0]  lmem [HALF];
    logic            lag_we;
    logic [LA_W-1:0] lag_waddr, lag_raddr;
    logic [D_W-1:0]  lag_wdata, lag_rdata_reg;

    // Shared serial divider.
    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_r0, div_divisor;
    logic [QB-1:0]    div_low, div_quot;

    // Cell chain.
    logic             cell_clr;
    ypd_pkg::link_t   chain [LANES+1];
    logic [D_W-1:0]   acc_w [LANES];

    assign chain[0].a   = ra_data_reg;
    assign chain[0].vld = rd_vld_reg;
    assign chain[0].b   = rb_data_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_cell
        ypd_cell #(
            .ACC_W (D_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clr      (cell_clr),
            .link_in  (chain[g]),
            .link_out (chain[g+1]),
            .acc      (acc_w[g])
        );
    end

    ypd_div #(
        .W (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .r0      (div_r0),
        .low     (div_low),
        .divisor (div_divisor),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (smem_we) begin
            smem[count_reg[SA_W-1:0]] <= s_tdata;
        end
        ra_data_reg <= smem[sa_addr];
        rb_data_reg <= smem[sb_addr];
    end

    always_ff @(posedge aclk) begin
        if (lag_we) begin
            lmem[lag_waddr] <= lag_wdata;
        end
        lag_rdata_reg <= lmem[lag_raddr];
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Working values used by several states.
    logic [CNT_W-1:0] cnt_new;
    logic [LW-1:0]    half_new, half_m1, lo_c, hi_c;
    logic [AX_W-1:0]  feed_end, b_sum, w_idx, t0_step;
    logic [NV_W-1:0]  cur, min_c;
    logic [LW-1:0]    best_c;
    logic signed [NV_W+3:0] s0w, s1w, s2w, dd;
    logic signed [NV_W+1:0] dsub;
    logic [NV_W+9:0]  an_full;
    logic [NV_W+3:0]  ad_full;
    logic [KX_W-1:0]  ky;
    logic signed [LW+10:0] per_s;
    logic [30:0]      nf;
    logic             norm_last;

    always_comb begin
        state_next      = state_reg;
        sr_next         = sr_reg;
        lmin_next       = lmin_reg;
        lmax_next       = lmax_reg;
        thr_next        = thr_reg;
        count_next      = count_reg;
        half_next       = half_reg;
        n_next          = n_reg;
        t0_next         = t0_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        rs_next         = rs_reg;
        prod_next       = prod_reg;
        hi_next         = hi_reg;
        best_next       = best_reg;
        tau_next        = tau_reg;
        min_next        = min_reg;
        val_next        = val_reg;
        s0_next         = s0_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        neg_next        = neg_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_freq_next   = res_freq_reg;
        res_period_next = res_period_reg;
        res_conf_next   = res_conf_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        m_tdata_next    = m_tdata_reg;

        smem_we     = 1'b0;
        feed_vld    = 1'b0;
        cell_clr    = 1'b0;
        lag_we      = 1'b0;
        lag_waddr   = t_reg[LA_W-1:0];
        lag_wdata   = '0;
        lag_raddr   = t_reg[LA_W-1:0];
        div_start   = 1'b0;
        div_r0      = '0;
        div_low     = '0;
        div_divisor = '0;

        cnt_new   = (count_reg < CNT_W'(WINDOW)) ? count_reg + 1'b1 : count_reg;
        half_new  = LW'(cnt_new >> 1);
        half_m1   = half_reg - 1'b1;
        feed_end  = AX_W'(half_reg) + AX_W'(2 * LANES + 4);
        b_sum     = AX_W'(t0_reg) + n_reg;
        w_idx     = AX_W'(t0_reg) + AX_W'(k_reg);
        t0_step   = AX_W'(t0_reg) + AX_W'(LANES);
        sa_addr   = n_reg[SA_W-1:0];
        sb_addr   = b_sum[SA_W-1:0];
        norm_last = (t_reg == half_m1);

        lo_c  = (lmin_reg < 10'd2) ? LW'(2) : LW'(lmin_reg);
        hi_c  = (LW'(lmax_reg) < half_m1) ? LW'(lmax_reg) : half_m1;
        cur   = lag_rdata_reg[NV_W-1:0];
        min_c = (cur < min_reg) ? cur : min_reg;
        best_c = (cur < min_reg) ? t_reg : best_reg;

        s0w  = (NV_W+4)'(s0_reg);
        s1w  = (NV_W+4)'(val_reg);
        s2w  = (NV_W+4)'(cur);
        dd   = s0w - (s1w <<< 1) + s2w;
        dsub = (NV_W+2)'(s0w - s2w);
        an_full = num_reg[NV_W+9] ? (NV_W+10)'(-num_reg) : (NV_W+10)'(num_reg);
        ad_full = den_reg[NV_W+3] ? (NV_W+4)'(-den_reg) : (NV_W+4)'(den_reg);
        ky      = (KX_W'(y_reg) << 8) + KX_W'(y_reg);
        per_s   = $signed((LW+11)'({tau_reg, 8'd0})) + (LW+11)'(off_reg);
        nf      = 31'({sr_reg, 12'd0}) + 31'(res_period_reg >> 1);

        // The user must write configuration only while idle; the block itself does not enforce this.
        if (cfg_we) begin
            case (cfg_index)
                ypd_pkg::REG_SAMPLE_RATE: sr_next   = cfg_wdata;
                ypd_pkg::REG_LAG_MIN:     lmin_next = cfg_wdata[9:0];
                ypd_pkg::REG_LAG_MAX:     lmax_next = cfg_wdata[9:0];
                ypd_pkg::REG_THRESHOLD:   thr_next  = cfg_wdata[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    smem_we    = (count_reg < CNT_W'(WINDOW));
                    count_next = cnt_new;
                    if (s_tlast) begin
                        count_next      = '0;
                        half_next       = half_new;
                        res_freq_next   = '0;
                        res_period_next = '0;
                        res_conf_next   = '0;
                        t0_next         = '0;
                        if (half_new < LW'(2)) begin
                            res_status_next = ypd_pkg::ST_SHORT;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_CLR;
                        end
                    end
                end
            end
            S_CLR: begin
                cell_clr   = 1'b1;
                n_next     = '0;
                state_next = S_FEED;
            end
            S_FEED: begin
                feed_vld = (n_reg < AX_W'(half_reg));
                n_next   = n_reg + 1'b1;
                if (n_reg == feed_end) begin
                    k_next     = '0;
                    state_next = S_WOUT;
                end
            end
            S_WOUT: begin
                if (w_idx < AX_W'(half_reg)) begin
                    lag_we    = 1'b1;
                    lag_waddr = w_idx[LA_W-1:0];
                    lag_wdata = acc_w[k_reg];
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LN_W'(LANES - 1)) begin
                    t0_next = t0_step[LW-1:0];
                    if (t0_step >= AX_W'(half_reg)) begin
                        t_next     = LW'(1);
                        rs_next    = '0;
                        state_next = S_N_RD;
                    end else begin
                        state_next = S_CLR;
                    end
                end
            end
            S_N_RD: begin
                state_next = S_N_MUL;
            end
            S_N_MUL: begin
                rs_next    = rs_reg + RS_W'(lag_rdata_reg);
                prod_next  = RS_W'(lag_rdata_reg) * RS_W'(t_reg[LA_W-1:0]);
                state_next = S_N_DIV0;
            end
            S_N_DIV0: begin
                if (rs_reg == '0) begin
                    // An empty running sum normalises to exactly one.
                    lag_we    = 1'b1;
                    lag_wdata = D_W'(ypd_pkg::NORM_ONE);
                    t_next    = t_reg + 1'b1;
                    state_next = norm_last ? S_BOUNDS : S_N_RD;
                end else begin
                    div_start   = 1'b1;
                    div_r0      = DIV_W'(prod_reg >> (QB - ypd_pkg::NORM_FRAC));
                    div_low     = {prod_reg[QB-ypd_pkg::NORM_FRAC-1:0],
                                   {ypd_pkg::NORM_FRAC{1'b0}}};
                    div_divisor = DIV_W'(rs_reg);
                    state_next  = S_N_DIV;
                end
            end
            S_N_DIV: begin
                if (div_done) begin
                    lag_we    = 1'b1;
                    lag_wdata = D_W'(div_quot);
                    t_next    = t_reg + 1'b1;
                    state_next = norm_last ? S_BOUNDS : S_N_RD;
                end
            end
            S_BOUNDS: begin
                if (lo_c >= hi_c) begin
                    res_status_next = ypd_pkg::ST_EMPTY;
                    state_next      = S_DONE;
                end else begin
                    hi_next    = hi_c;
                    t_next     = lo_c;
                    best_next  = lo_c;
                    min_next   = '1;
                    state_next = S_F_RD;
                end
            end
            S_F_RD: begin
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (cur < NV_W'(thr_reg)) begin
                    tau_next   = t_reg;
                    val_next   = cur;
                    state_next = S_D_RD;
                end else begin
                    min_next  = min_c;
                    best_next = best_c;
                    if (t_reg == hi_reg) begin
                        if (min_c < NV_W'(ypd_pkg::FALLBACK_LIMIT)) begin
                            tau_next   = best_c;
                            val_next   = min_c;
                            state_next = S_I_RD0;
                        end else begin
                            res_status_next = ypd_pkg::ST_NONE;
                            state_next      = S_DONE;
                        end
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_F_RD;
                    end
                end
            end
            S_D_RD: begin
                lag_raddr = LA_W'(tau_reg + 1'b1);
                if (tau_reg + 1'b1 > hi_reg) begin
                    state_next = S_I_RD0;
                end else begin
                    state_next = S_D_CHK;
                end
            end
            S_D_CHK: begin
                if (cur < val_reg) begin
                    tau_next   = tau_reg + 1'b1;
                    val_next   = cur;
                    state_next = S_D_RD;
                end else begin
                    state_next = S_I_RD0;
                end
            end
            S_I_RD0: begin
                lag_raddr = LA_W'(tau_reg - 1'b1);
                if (tau_reg + 1'b1 >= half_reg) begin
                    off_next   = '0;
                    state_next = S_PER;
                end else begin
                    state_next = S_I_RD2;
                end
            end
            S_I_RD2: begin
                s0_next    = cur;
                lag_raddr  = LA_W'(tau_reg + 1'b1);
                state_next = S_I_CALC;
            end
            S_I_CALC: begin
                num_next   = {dsub, 8'd0};
                den_next   = {dd[NV_W+2:0], 1'b0};
                state_next = S_I_PREP;
            end
            S_I_PREP: begin
                if (den_reg == '0) begin
                    off_next   = '0;
                    state_next = S_PER;
                end else begin
                    x_next     = (XW'(an_full) << 1) + XW'(ad_full);
                    y_next     = ad_full << 1;
                    neg_next   = num_reg[NV_W+9] ^ den_reg[NV_W+3];
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK: begin
                // Quotients beyond one lag clamp without dividing.
                if (KX_W'(x_reg) >= ky) begin
                    off_next   = neg_reg ? -10'sd256 : 10'sd256;
                    state_next = S_PER;
                end else begin
                    div_start   = 1'b1;
                    div_r0      = DIV_W'(x_reg >> QB);
                    div_low     = x_reg[QB-1:0];
                    div_divisor = DIV_W'(y_reg);
                    state_next  = S_I_DIV;
                end
            end
            S_I_DIV: begin
                if (div_done) begin
                    off_next   = neg_reg ? -$signed({1'b0, div_quot[8:0]})
                                         :  $signed({1'b0, div_quot[8:0]});
                    state_next = S_PER;
                end
            end
            S_PER: begin
                if (per_s > $signed((LW+11)'(ypd_pkg::PERIOD_MAX))) begin
                    res_period_next = ypd_pkg::PERIOD_MAX;
                end else begin
                    res_period_next = per_s[17:0];
                end
                state_next = S_Q_DIV;
                div_start  = 1'b1;
            end
            S_Q_DIV: begin
                if (div_done) begin
                    res_freq_next   = (div_quot > QB'(ypd_pkg::FREQ_MAX))
                                      ? ypd_pkg::FREQ_MAX : div_quot[21:0];
                    res_conf_next   = ypd_pkg::NORM_ONE - 17'(val_reg);
                    res_status_next = ypd_pkg::ST_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, res_conf_reg, res_period_reg,
                                     res_freq_reg, res_status_reg};
                    state_next    = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        // The frequency division starts from the period being registered,
        // with half of it added for rounding.
        if (state_reg == S_PER) begin
            nf          = 31'({sr_reg, 12'd0}) + 31'(res_period_next >> 1);
            div_r0      = DIV_W'(nf >> QB);
            div_low     = nf[QB-1:0];
            div_divisor = DIV_W'(res_period_next);
        end
    end

    always_ff @(posedge aclk) begin
        half_reg       <= half_next;
        n_reg          <= n_next;
        t0_reg         <= t0_next;
        k_reg          <= k_next;
        t_reg          <= t_next;
        rs_reg         <= rs_next;
        prod_reg       <= prod_next;
        hi_reg         <= hi_next;
        best_reg       <= best_next;
        tau_reg        <= tau_next;
        min_reg        <= min_next;
        val_reg        <= val_next;
        s0_reg         <= s0_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        neg_reg        <= neg_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_freq_reg   <= res_freq_next;
        res_period_reg <= res_period_next;
        res_conf_reg   <= res_conf_next;
        m_tdata_reg    <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            sr_reg       <= ypd_pkg::SR_RESET;
            lmin_reg     <= ypd_pkg::LMIN_RESET;
            lmax_reg     <= ypd_pkg::LMAX_RESET;
            thr_reg      <= ypd_pkg::THR_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sr_reg       <= sr_next;
            lmin_reg     <= lmin_next;
            lmax_reg     <= lmax_next;
            thr_reg      <= thr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= feed_vld;
        end
    end

    // The divider is never restarted while a division is still running.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // The sample count never passes the window length.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW))
        else $error("sample count beyond window");

    // Lag entries are only written below half the window count.
    a_lag_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        lag_we |-> (LW'(lag_waddr) < half_reg))
        else $error("lag write beyond half window");

    // A failed window reports zero frequency, period and confidence.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg) && m_tdata_reg[1:0] != ypd_pkg::ST_FOUND)
        |-> (m_tdata_reg[63:2] == '0))
        else $error("failed result carries non-zero fields");

endmodule

`default_nettype wire

FILE: src/ypd_cell.sv
`default_nettype none

// One lag of the difference function. The reference sample moves on by two
// registers per cell, the shifted sample by one, so each cell sees the pair
// that belongs to its own lag.
module ypd_cell #(
    parameter int ACC_W = 42
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clr,
    input  wire ypd_pkg::link_t link_in,
    output      ypd_pkg::link_t link_out,
    output      logic [ACC_W-1:0] acc
);

    logic signed [15:0] a1_reg, a2_reg, b_reg;
    logic               v1_reg, v2_reg;
    logic [15:0]        mag_reg;
    logic               dv_reg;
    logic [31:0]        sq_reg;
    logic               sv_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic signed [16:0] diff;
    logic [16:0]        mag_full;

    always_comb begin
        diff     = 17'(link_in.a) - 17'(link_in.b);
        mag_full = diff[16] ? 17'(-diff) : 17'(diff);
    end

    always_ff @(posedge aclk) begin
        a1_reg  <= link_in.a;
        a2_reg  <= a1_reg;
        b_reg   <= link_in.b;
        mag_reg <= mag_full[15:0];
        sq_reg  <= 32'(mag_reg) * 32'(mag_reg);
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            dv_reg  <= 1'b0;
            sv_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= link_in.vld;
            v2_reg <= v1_reg;
            dv_reg <= link_in.vld;
            sv_reg <= dv_reg;
            if (clr) begin
                acc_reg <= '0;
            end else if (sv_reg) begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
            end
        end
    end

    assign link_out.a   = a2_reg;
    assign link_out.vld = v2_reg;
    assign link_out.b   = b_reg;
    assign acc          = acc_reg;

endmodule

`default_nettype wire

FILE: src/ypd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The starting remainder must
// be below the divisor; the low word is shifted in from its top bit.
module ypd_div #(
    parameter int W = 53
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [W-1:0]          r0,
    input  wire logic [ypd_pkg::QB-1:0] low,
    input  wire logic [W-1:0]          divisor,
    output      logic                  busy,
    output      logic                  done,
    output      logic [ypd_pkg::QB-1:0] quot
);

    localparam int CW = $clog2(ypd_pkg::QB + 1);

    logic [W-1:0]           r_reg, div_reg;
    logic [ypd_pkg::QB-1:0] low_reg, q_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic [W:0]             r2, r2_sub;
    logic                   ge;

    always_comb begin
        r2     = {r_reg, low_reg[ypd_pkg::QB-1]};
        ge     = r2 >= {1'b0, div_reg};
        r2_sub = r2 - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= r0;
            low_reg <= low;
            div_reg <= divisor;
        end else if (busy_reg && cnt_reg != '0) begin
            r_reg   <= ge ? r2_sub[W-1:0] : r2[W-1:0];
            low_reg <= {low_reg[ypd_pkg::QB-2:0], 1'b0};
            q_reg   <= {q_reg[ypd_pkg::QB-2:0], ge};
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(ypd_pkg::QB);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_reg;

endmodule

`default_nettype wire
